FILE: sv/rational_arithmetic_unit_core_assert.svh
// assertion macros shared by the rational unit
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// implication checked every clock, off while in reset
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/rau_pkg.sv
`default_nettype none
package rau_pkg;
    localparam int INT_BITS_DEF = 32;
    localparam int FIELD_BITS = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_INT = 3'd5,
        OP_NORM = 3'd6,
        OP_BAD = 3'd7
    } op_t;

    // datapath step selects
    typedef enum logic [3:0] {
        DP_NONE  = 4'd0,
        DP_LOAD  = 4'd1,
        DP_MUL0  = 4'd2,
        DP_MUL1  = 4'd3,
        DP_MUL2  = 4'd4,
        DP_MUL3  = 4'd5,
        DP_FORM  = 4'd6,
        DP_GINIT = 4'd7,
        DP_GSTEP = 4'd8,
        DP_DIVN  = 4'd9,
        DP_DIVD  = 4'd10,
        DP_DSTEP = 4'd11,
        DP_SAVEN = 4'd12,
        DP_QINIT = 4'd13,
        DP_FIN   = 4'd14
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
    } ctrl_t;

    typedef struct packed {
        logic g_done;     // gcd loop finished
        logic g_zero;     // gcd result is zero
        logic div_done;   // divider finished
    } stat_t;
endpackage
`default_nettype wire

FILE: sv/rau_datapath.sv
`default_nettype none
`include "rational_arithmetic_unit_core_assert.svh"
module rau_datapath #(
    parameter int INT_BITS = rau_pkg::INT_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rau_pkg::ctrl_t                  ctrl,
    output rau_pkg::stat_t                       stat,
    input  wire logic [2:0]                      mode,
    input  wire logic signed [rau_pkg::FIELD_BITS-1:0] a_num,
    input  wire logic signed [rau_pkg::FIELD_BITS-1:0] a_den,
    input  wire logic signed [rau_pkg::FIELD_BITS-1:0] b_num,
    input  wire logic signed [rau_pkg::FIELD_BITS-1:0] b_den,
    output logic signed [rau_pkg::FIELD_BITS-1:0] res_num,
    output logic signed [rau_pkg::FIELD_BITS-1:0] res_den,
    output logic                                 error
);
    localparam int W = INT_BITS;
    localparam int FB = rau_pkg::FIELD_BITS;
    localparam int CW = $clog2(W + 1);

    logic [2:0]   mode_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [W-1:0] m_reg;           // product register
    logic [W-1:0] acc_reg;
    logic [W-1:0] p_reg, q_reg;    // fraction before reduction
    logic [W-1:0] ga_reg, gb_reg;  // gcd operands; ga ends as the gcd
    logic [W-1:0] dv_reg, rm_reg, qt_reg;
    logic [CW-1:0] cnt_reg;
    logic         dneg_reg;
    logic [W-1:0] numq_reg;
    logic [FB-1:0] rn_reg, rd_reg;
    logic         err_reg;
    logic         mod_mode_reg;    // divider used for gcd remainder

    logic [W-1:0] mul_x, mul_y, mul_p;
    logic [W:0]   rem_try;
    logic [W-1:0] rem_sh;

    function automatic logic [W-1:0] ext(input logic [FB-1:0] v);
        logic [W+FB-1:0] t;
        t = {{W{v[FB-1]}}, v};
        return t[W-1:0];
    endfunction

    function automatic logic [FB-1:0] tofield(input logic [W-1:0] v);
        logic [W+FB-1:0] t;
        t = {{FB{v[W-1]}}, v};
        return t[FB-1:0];
    endfunction

    function automatic logic [W-1:0] magw(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // one shared multiplier, operands chosen by step
    always_comb
    begin
        mul_x = an_reg;
        mul_y = bd_reg;
        unique case (ctrl.cmd)
            rau_pkg::DP_MUL0:
            begin
                mul_x = an_reg;
                mul_y = (mode_reg == rau_pkg::OP_MUL) ? bn_reg : bd_reg;
            end
            rau_pkg::DP_MUL1:
            begin
                mul_x = bn_reg;
                mul_y = ad_reg;
            end
            rau_pkg::DP_MUL2:
            begin
                mul_x = ad_reg;
                mul_y = bd_reg;
            end
            default:
            begin
                mul_x = an_reg;
                mul_y = bd_reg;
            end
        endcase
        mul_p = mul_x * mul_y;
    end

    // restoring division step: remainder shifts in next dividend bit
    always_comb
    begin
        rem_sh  = {rm_reg[W-2:0], qt_reg[W-1]};
        rem_try = {rm_reg, qt_reg[W-1]} - {1'b0, dv_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            unique case (ctrl.cmd)
                rau_pkg::DP_LOAD:
                begin
                    mode_reg <= mode;
                    an_reg <= ext(a_num);
                    ad_reg <= ext(a_den);
                    bn_reg <= ext(b_num);
                    bd_reg <= ext(b_den);
                end
                rau_pkg::DP_MUL0:
                    m_reg <= mul_p;
                rau_pkg::DP_MUL1:
                begin
                    acc_reg <= m_reg;
                    m_reg <= mul_p;
                end
                rau_pkg::DP_MUL2:
                begin
                    // only add and subtract combine the two cross products
                    if (mode_reg == rau_pkg::OP_SUB)
                        acc_reg <= acc_reg - m_reg;
                    else if (mode_reg == rau_pkg::OP_ADD)
                        acc_reg <= acc_reg + m_reg;
                    // divide keeps bn*ad as its denominator
                    if (mode_reg != rau_pkg::OP_DIV)
                        m_reg <= mul_p;
                end
                rau_pkg::DP_MUL3:
                    ;
                rau_pkg::DP_FORM:
                begin
                    unique case (mode_reg) inside
                        rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL, rau_pkg::OP_DIV:
                        begin
                            p_reg <= acc_reg;
                            q_reg <= m_reg;
                        end
                        rau_pkg::OP_NEG:
                        begin
                            p_reg <= ~an_reg + 1'b1;
                            q_reg <= ad_reg;
                        end
                        default:
                        begin
                            p_reg <= an_reg;
                            q_reg <= ad_reg;
                        end
                    endcase
                end
                rau_pkg::DP_GINIT:
                begin
                    ga_reg <= magw(p_reg);
                    gb_reg <= magw(q_reg);
                end
                rau_pkg::DP_GSTEP:
                begin
                    // start a remainder ga % gb on the divider
                    qt_reg  <= ga_reg;
                    dv_reg  <= gb_reg;
                    rm_reg  <= '0;
                    cnt_reg <= CW'(W);
                    mod_mode_reg <= 1'b1;
                end
                rau_pkg::DP_DIVN:
                begin
                    qt_reg  <= magw(p_reg);
                    dv_reg  <= ga_reg;
                    rm_reg  <= '0;
                    cnt_reg <= CW'(W);
                    dneg_reg <= p_reg[W-1];
                    mod_mode_reg <= 1'b0;
                end
                rau_pkg::DP_SAVEN:
                    numq_reg <= dneg_reg ? (~qt_reg + 1'b1) : qt_reg;
                rau_pkg::DP_DIVD:
                begin
                    qt_reg  <= magw(q_reg);
                    dv_reg  <= ga_reg;
                    rm_reg  <= '0;
                    cnt_reg <= CW'(W);
                    dneg_reg <= q_reg[W-1];
                    mod_mode_reg <= 1'b0;
                end
                rau_pkg::DP_QINIT:
                begin
                    qt_reg  <= magw(an_reg);
                    dv_reg  <= magw(ad_reg);
                    rm_reg  <= '0;
                    cnt_reg <= CW'(W);
                    dneg_reg <= an_reg[W-1] ^ ad_reg[W-1];
                    mod_mode_reg <= 1'b0;
                end
                rau_pkg::DP_DSTEP:
                begin
                    if (cnt_reg != '0)
                    begin
                        if (!rem_try[W])
                        begin
                            rm_reg <= rem_try[W-1:0];
                            qt_reg <= {qt_reg[W-2:0], 1'b1};
                        end
                        else
                        begin
                            rm_reg <= rem_sh;
                            qt_reg <= {qt_reg[W-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    else if (mod_mode_reg)
                    begin
                        // euclid update
                        ga_reg <= gb_reg;
                        gb_reg <= rm_reg;
                        mod_mode_reg <= 1'b0;
                    end
                end
                rau_pkg::DP_FIN:
                begin
                    unique case (mode_reg)
                        rau_pkg::OP_INT:
                        begin
                            err_reg <= (ad_reg == '0);
                            rd_reg  <= '0;
                            rn_reg  <= (ad_reg == '0) ? '0 :
                                       tofield(dneg_reg ? (~qt_reg + 1'b1) : qt_reg);
                        end
                        rau_pkg::OP_BAD:
                        begin
                            err_reg <= 1'b1;
                            rn_reg <= '0;
                            rd_reg <= '0;
                        end
                        default:
                        begin
                            err_reg <= (ga_reg == '0);
                            rn_reg  <= (ga_reg == '0) ? '0 : tofield(numq_reg);
                            rd_reg  <= (ga_reg == '0) ? '0 :
                                       tofield(dneg_reg ? (~qt_reg + 1'b1) : qt_reg);
                        end
                    endcase
                end
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        stat.g_done   = (gb_reg == '0);
        stat.g_zero   = (ga_reg == '0);
        stat.div_done = (cnt_reg == '0) && !mod_mode_reg;
    end

    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign error   = err_reg;

    `RAU_ASSERT_NEXT(a_cnt_load, clk, rst_n, ctrl.cmd == rau_pkg::DP_QINIT, cnt_reg == CW'(W))
    `RAU_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CW'(W))
    `RAU_ASSERT_NEXT(a_bad_err, clk, rst_n,
        ctrl.cmd == rau_pkg::DP_FIN && mode_reg == rau_pkg::OP_BAD, err_reg)
endmodule
`default_nettype wire

FILE: sv/rau_ctrl.sv
`default_nettype none
`include "rational_arithmetic_unit_core_assert.svh"
module rau_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [2:0]     mode,
    input  wire rau_pkg::stat_t stat,
    output rau_pkg::ctrl_t      ctrl,
    output logic                busy,
    output logic                done
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_MUL0  = 11'b00000000010,
        S_MUL1  = 11'b00000000100,
        S_MUL2  = 11'b00000001000,
        S_FORM  = 11'b00000010000,
        S_GINIT = 11'b00000100000,
        S_GCD   = 11'b00001000000,
        S_GMOD  = 11'b00010000000,
        S_DIVN  = 11'b00100000000,
        S_DIVD  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;   // 0 numerator, 1 denominator divide
    logic   mode_int_reg, mode_int_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        mode_int_next = mode_int_reg;
        done_next = 1'b0;
        ctrl.cmd = rau_pkg::DP_NONE;
        unique case (state_reg)
            S_IDLE:
                // the result strobe cycle still counts as busy
                if (start && !done_reg)
                begin
                    ctrl.cmd = rau_pkg::DP_LOAD;
                    mode_int_next = (mode == rau_pkg::OP_INT);
                    state_next = (mode == rau_pkg::OP_INT) ? S_FORM : S_MUL0;
                end
            S_MUL0:
            begin
                ctrl.cmd = rau_pkg::DP_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                ctrl.cmd = rau_pkg::DP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                ctrl.cmd = rau_pkg::DP_MUL2;
                state_next = S_FORM;
            end
            S_FORM:
            begin
                ctrl.cmd = mode_int_reg ? rau_pkg::DP_QINIT : rau_pkg::DP_FORM;
                state_next = mode_int_reg ? S_DIVD : S_GINIT;
                phase_next = 1'b1;
            end
            S_GINIT:
            begin
                ctrl.cmd = rau_pkg::DP_GINIT;
                state_next = S_GCD;
            end
            S_GCD:
                if (stat.g_done)
                begin
                    if (stat.g_zero)
                        state_next = S_OUT;
                    else
                    begin
                        ctrl.cmd = rau_pkg::DP_DIVN;
                        phase_next = 1'b0;
                        state_next = S_DIVN;
                    end
                end
                else
                begin
                    ctrl.cmd = rau_pkg::DP_GSTEP;
                    state_next = S_GMOD;
                end
            S_GMOD:
            begin
                ctrl.cmd = rau_pkg::DP_DSTEP;
                if (stat.div_done)
                    state_next = S_GCD;
            end
            S_DIVN:
                if (stat.div_done)
                begin
                    ctrl.cmd = rau_pkg::DP_SAVEN;
                    state_next = S_DIVD;
                end
                else
                    ctrl.cmd = rau_pkg::DP_DSTEP;
            S_DIVD:
                if (!phase_reg)
                begin
                    ctrl.cmd = rau_pkg::DP_DIVD;
                    phase_next = 1'b1;
                end
                else if (stat.div_done)
                    state_next = S_OUT;
                else
                    ctrl.cmd = rau_pkg::DP_DSTEP;
            S_OUT:
            begin
                ctrl.cmd = rau_pkg::DP_FIN;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
            mode_int_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            mode_int_reg <= mode_int_next;
            done_reg <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;

    `RAU_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `RAU_ASSERT_NEXT(a_done_after_out, clk, rst_n, state_reg == S_OUT, done_reg)
    `RAU_ASSERT_IMP(a_done_busy, clk, rst_n, done_reg, busy)
endmodule
`default_nettype wire

FILE: sv/rational_arithmetic_unit_core.sv
// rational arithmetic unit: one fraction operation per command word
// start is taken when busy is low; operands and mode are captured then
// modes: add, subtract, multiply, divide, negate, to integer, normalize
// cross products go through one shared multiplier, one product a cycle
// the result is reduced by the gcd found with euclid's algorithm, each
// remainder from a restoring divider at one bit a cycle, then numerator
// and denominator are divided by the gcd on the same divider
// to-integer skips the gcd and divides the numerator by the denominator
// one word at a time: busy stays high until the result strobe has passed,
// so the next word can be taken in the cycle after done
// done pulses for one cycle with res_num, res_den and error valid;
// the receiver cannot stall, so the word must be taken in that cycle
// error is set for a zero gcd, a zero denominator in to-integer, or mode 7
// reset clears the controller to idle; no result is pending after reset
`default_nettype none
module rational_arithmetic_unit_core #(
    parameter int INT_BITS = rau_pkg::INT_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    output logic                                       done,
    input  wire logic [2:0]                            mode,
    input  wire logic signed [rau_pkg::FIELD_BITS-1:0] a_num,
    input  wire logic signed [rau_pkg::FIELD_BITS-1:0] a_den,
    input  wire logic signed [rau_pkg::FIELD_BITS-1:0] b_num,
    input  wire logic signed [rau_pkg::FIELD_BITS-1:0] b_den,
    output logic signed [rau_pkg::FIELD_BITS-1:0]      res_num,
    output logic signed [rau_pkg::FIELD_BITS-1:0]      res_den,
    output logic                                       error
);
    rau_pkg::ctrl_t ctrl;
    rau_pkg::stat_t stat;

    rau_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    rau_datapath #(
        .INT_BITS (INT_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .stat    (stat),
        .mode    (mode),
        .a_num   (a_num),
        .a_den   (a_den),
        .b_num   (b_num),
        .b_den   (b_den),
        .res_num (res_num),
        .res_den (res_den),
        .error   (error)
    );
endmodule
`default_nettype wire

FILE: sim/tb_rational_arithmetic_unit_core.sv
`default_nettype none
module tb_rational_arithmetic_unit_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_WORDS = 680;
    localparam int TAIL_WORDS = 100;

    typedef struct packed {
        logic signed [31:0] num;
        logic signed [31:0] den;
        logic               err;
    } frac_word_t;

    int unsigned n_errors;

    task automatic report(input string what);
        n_errors++;
        $display("mismatch: %s", what);
    endtask

    // magnitude as unsigned, the most negative value maps to 2^31
    function automatic logic [31:0] abs_of(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] euclid(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic [31:0] div_keep_sign(input logic [31:0] v, input logic [31:0] g);
        logic [31:0] q;
        q = abs_of(v) / g;
        return v[31] ? (~q + 32'd1) : q;
    endfunction

    function automatic frac_word_t reduced(input logic [31:0] p, input logic [31:0] q);
        frac_word_t r;
        logic [31:0] g;
        g = euclid(abs_of(p), abs_of(q));
        r = '0;
        if (g == 0)
            r.err = 1'b1;
        else
        begin
            r.num = div_keep_sign(p, g);
            r.den = div_keep_sign(q, g);
        end
        return r;
    endfunction

    function automatic frac_word_t rational_op(input rau_pkg::op_t op, input logic [31:0] an,
                                               input logic [31:0] ad, input logic [31:0] bn,
                                               input logic [31:0] bd);
        frac_word_t r;
        logic [31:0] q;
        r = '0;
        case (op)
            rau_pkg::OP_ADD:  r = reduced(an * bd + bn * ad, ad * bd);
            rau_pkg::OP_SUB:  r = reduced(an * bd - bn * ad, ad * bd);
            rau_pkg::OP_MUL:  r = reduced(an * bn, ad * bd);
            rau_pkg::OP_DIV:  r = reduced(an * bd, bn * ad);
            rau_pkg::OP_NEG:  r = reduced(~an + 32'd1, ad);
            rau_pkg::OP_INT:
            begin
                if (ad == 0)
                    r.err = 1'b1;
                else
                begin
                    q = abs_of(an) / abs_of(ad);
                    r.num = (an[31] != ad[31]) ? (~q + 32'd1) : q;
                end
            end
            rau_pkg::OP_NORM: r = reduced(an, ad);
            default: r.err = 1'b1;
        endcase
        return r;
    endfunction

    class frac_scoreboard;
        frac_word_t pending[$];

        function void note_command(rau_pkg::op_t op, logic [31:0] an, logic [31:0] ad,
                                   logic [31:0] bn, logic [31:0] bd);
            pending.push_back(rational_op(op, an, ad, bn, bd));
        endfunction

        task check_word(logic [31:0] num, logic [31:0] den, logic err);
            frac_word_t exp_w;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected word %h/%h err=%b", num, den, err));
                return;
            end
            exp_w = pending.pop_front();
            if (num !== exp_w.num)
                report($sformatf("res_num %h, want %h", num, exp_w.num));
            if (den !== exp_w.den)
                report($sformatf("res_den %h, want %h", den, exp_w.den));
            if (err !== exp_w.err)
                report($sformatf("error %b, want %b", err, exp_w.err));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    logic [2:0] mode;
    logic signed [31:0] a_num, a_den, b_num, b_den;
    logic signed [31:0] res_num, res_den;
    logic error;

    frac_scoreboard sb;
    bit gaps_on;
    int unsigned idle_cycles;

    rational_arithmetic_unit_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .mode(mode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .res_num(res_num), .res_den(res_den), .error(error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_word(res_num, res_den, error);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // start stays high between words unless a gap is taken or the queue is drained
    task automatic send_word(input rau_pkg::op_t op, input logic [31:0] an,
                             input logic [31:0] ad, input logic [31:0] bn,
                             input logic [31:0] bd);
        int gap;
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= op;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(op, an, ad, bn, bd);
    endtask

    // mostly small operands so products stay exact, some full width
    function automatic logic [31:0] pick_value(input bit nonzero);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 40) - 20;
            4, 5:       v = $urandom_range(0, 2000) - 1000;
            6:          v = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'd0} >> $urandom_range(0, 3);
            7:          v = 32'h8000_0000;
            default:    v = $urandom;
        endcase
        if (nonzero && v == 0)
            v = 1;
        return v;
    endfunction

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rau_pkg::op_t op;
        logic [31:0] d_a;
        sb = new();
        n_errors = 0;
        idle_cycles = 0;
        gaps_on = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = rau_pkg::OP_ADD;
        a_num = 0;
        a_den = 1;
        b_num = 0;
        b_den = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(rau_pkg::OP_ADD, 1, 2, 1, 3);
        send_word(rau_pkg::OP_SUB, 1, 2, 1, 2);
        send_word(rau_pkg::OP_MUL, -3, 4, 2, 9);
        send_word(rau_pkg::OP_DIV, 3, 4, 0, 5);
        send_word(rau_pkg::OP_DIV, 2, 5, -4, 7);
        send_word(rau_pkg::OP_NEG, 32'h8000_0000, 1, 0, 1);
        send_word(rau_pkg::OP_NEG, 6, -8, 0, 1);
        send_word(rau_pkg::OP_INT, -7, 2, 0, 1);
        send_word(rau_pkg::OP_INT, 32'h8000_0000, -1, 0, 1);
        send_word(rau_pkg::OP_INT, 5, 0, 0, 1);
        send_word(rau_pkg::OP_NORM, 0, 0, 0, 0);
        send_word(rau_pkg::OP_NORM, 32'h8000_0000, 32'h8000_0000, 0, 1);
        send_word(rau_pkg::OP_NORM, 32'h8000_0000, 6, 0, 1);
        send_word(rau_pkg::OP_NORM, 32'h7fff_ffff, 32'hffff_ffff, 0, 1);
        send_word(rau_pkg::OP_NORM, 12, -18, 0, 1);
        send_word(rau_pkg::OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
        send_word(rau_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000,
                  32'h7fff_ffff);
        send_word(rau_pkg::OP_BAD, 3, 4, 5, 6);
        send_word(rau_pkg::OP_BAD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff);

        gaps_on = 1'b1;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            op = rau_pkg::op_t'($urandom_range(0, 7));
            d_a = pick_value(op == rau_pkg::OP_INT ? $urandom_range(0, 9) != 0 : 1'b0);
            send_word(op, pick_value(0), d_a, pick_value(0), pick_value(0));
            if (i == RANDOM_WORDS / 2)
                wait_drained();
        end
        gaps_on = 1'b0;
        for (int i = 0; i < TAIL_WORDS; i++)
            send_word(rau_pkg::op_t'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                      $urandom);

        wait_drained();
        repeat (400) @(posedge clk);
        if (n_errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
+incdir+sv
sv/rau_pkg.sv
sv/rau_datapath.sv
sv/rau_ctrl.sv
sv/rational_arithmetic_unit_core.sv
sim/tb_rational_arithmetic_unit_core.sv
